// ===== hdl/stre_pkg.sv =====
// Shared types and constants for the spanning tree root election block.
// No dependencies; imported by every module of the block.
package stre_pkg;

   localparam int MASK_W  = 8;
   localparam int PORT_W  = 3;
   localparam int ID_W    = 16;
   localparam int COST_W  = 24;
   localparam int LINK_W  = 16;
   localparam int RPORT_W = 4;
   localparam int SUM_W   = COST_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [RPORT_W-1:0] NO_PORT = RPORT_W'(8);

   localparam logic REQ_ADVERT   = 1'b0;
   localparam logic REQ_ANNOUNCE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_MASK = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [PORT_W-1:0] arrive_port;
      logic [ID_W-1:0]   msg_root_id;
      logic [COST_W-1:0] msg_cost;
      logic [LINK_W-1:0] link_cost;
      logic              batch_last;
   } req_item_type;

   typedef struct packed {
      logic [PORT_W-1:0]  out_port;
      logic [ID_W-1:0]    out_root_id;
      logic [COST_W-1:0]  out_cost;
      logic [RPORT_W-1:0] root_port;
      logic               out_last;
   } rsp_item_type;

   // one announcement: state snapshot and the ports still to send on
   typedef struct packed {
      logic [ID_W-1:0]    root_id;
      logic [COST_W-1:0]  cost;
      logic [RPORT_W-1:0] root_port;
      logic [MASK_W-1:0]  send_mask;
   } job_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

// ===== hdl/stre_front.sv =====
// Front end: takes items, runs the root comparison, holds election state
// and config, and queues announcement jobs. Uses stre_pkg.
module stre_front
   import stre_pkg::*;
#(
   parameter int PORTS     = 8,
   parameter int COST_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  queue_status_type      q_status,
   output logic                  push,
   output job_type               push_job
);

   localparam logic [32:0] COST_MAX = (33'd1 << COST_BITS) - 33'd1;

   function automatic logic [MASK_W-1:0] port_limit();
      logic [MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (i < PORTS) m[i] = 1'b1;
      end
      return m;
   endfunction

   localparam logic [MASK_W-1:0] PORT_LIMIT = port_limit();

   logic [MASK_W-1:0]  port_mask_ff, port_mask_in;
   logic [ID_W-1:0]    best_root_ff, best_root_in;
   logic [SUM_W-1:0]   best_cost_ff, best_cost_in;
   logic [RPORT_W-1:0] toward_ff, toward_in;
   logic [PORT_W-1:0]  sender_ff, sender_in;
   logic               changed_ff, changed_in;

   logic              accept, advert, better;
   logic [SUM_W-1:0]  total, total_sat;
   logic [MASK_W-1:0] active;

   assign req_ready = ~q_status.full;
   assign accept    = req_valid & req_ready;
   assign advert    = accept & (req_data.req_type == REQ_ADVERT);
   assign active    = port_mask_ff & PORT_LIMIT;

   assign total     = {1'b0, req_data.msg_cost} + SUM_W'(req_data.link_cost);
   assign total_sat = ({8'd0, total} > COST_MAX) ? COST_MAX[SUM_W-1:0] : total;
   assign better    = (req_data.msg_root_id < best_root_ff) ||
                      ((req_data.msg_root_id == best_root_ff) && (total_sat < best_cost_ff));

   always_comb begin
      port_mask_in = port_mask_ff;
      best_root_in = best_root_ff;
      best_cost_in = best_cost_ff;
      toward_in    = toward_ff;
      sender_in    = sender_ff;
      changed_in   = changed_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_OWN_ID: begin
               best_root_in = csr_data[ID_W-1:0];
               best_cost_in = '0;
               toward_in    = NO_PORT;
               sender_in    = '0;
               changed_in   = 1'b0;
            end
            CSR_PORT_MASK: port_mask_in = csr_data[MASK_W-1:0];
            default: ;
         endcase
      end else if (advert) begin
         if (better) begin
            best_root_in = req_data.msg_root_id;
            best_cost_in = total_sat;
            toward_in    = RPORT_W'(req_data.arrive_port);
            sender_in    = req_data.arrive_port;
         end
         changed_in = req_data.batch_last ? 1'b0 : (changed_ff | better);
      end
   end

   always_comb begin
      push_job.root_id   = best_root_in;
      push_job.cost      = best_cost_in[COST_W-1:0];
      push_job.root_port = toward_in;
      push_job.send_mask = '0;
      if (accept && req_data.req_type == REQ_ANNOUNCE) begin
         push_job.send_mask = active;
      end else if (advert && req_data.batch_last && (changed_ff || better)) begin
         push_job.send_mask = active & ~(MASK_W'(1) << sender_in);
      end
   end

   assign push = ~csr_write & (push_job.send_mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         port_mask_ff <= '0;
         best_root_ff <= '0;
         best_cost_ff <= '0;
         toward_ff    <= NO_PORT;
         sender_ff    <= '0;
         changed_ff   <= 1'b0;
      end else begin
         port_mask_ff <= port_mask_in;
         best_root_ff <= best_root_in;
         best_cost_ff <= best_cost_in;
         toward_ff    <= toward_in;
         sender_ff    <= sender_in;
         changed_ff   <= changed_in;
      end
   end

endmodule

// ===== hdl/stre_queue.sv =====
// Short job queue between the front and back ends.
// Uses stre_pkg for the job type and depth.
module stre_queue
   import stre_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign do_push = push & ~status.full;
   assign do_pop  = pop & status.valid;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/stre_back.sv =====
// Back end: walks one job's port mask into the result register, one result
// per cycle while rsp_ready or an empty register allows. Uses stre_pkg.
module stre_back
   import stre_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_item_type     rsp_data
);

   job_type           cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;
   logic [MASK_W-1:0] low_bit, rest;
   logic [PORT_W-1:0] low_idx;
   logic              emit, cur_done;

   assign low_bit = cur_ff.send_mask & (~cur_ff.send_mask + 1'b1);
   assign rest    = cur_ff.send_mask & ~low_bit;

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (low_bit[i]) low_idx = PORT_W'(i);
      end
   end

   assign emit     = (cur_ff.send_mask != '0) & (~rsp_valid_ff | rsp_ready);
   assign cur_done = (cur_ff.send_mask == '0) | (emit & (rest == '0));
   assign pop      = cur_done & q_status.valid;

   always_comb begin
      cur_in = cur_ff;
      if (pop) cur_in = head;
      else if (emit) cur_in.send_mask = rest;
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_data_in.out_port    = low_idx;
         rsp_data_in.out_root_id = cur_ff.root_id;
         rsp_data_in.out_cost    = cur_ff.cost;
         rsp_data_in.root_port   = cur_ff.root_port;
         rsp_data_in.out_last    = (rest == '0);
      end
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.send_mask <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cur_ff           <= cur_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/spanning_tree_root_election.sv =====
// Top level of the spanning tree root election block: front end, job
// queue and back end. Uses stre_pkg, stre_front, stre_queue, stre_back.
//
// One request item is taken every cycle while the four-entry job queue has
// room; the comparison and state update finish in that cycle. A batch end
// that changed the best root or cost, or an announce request, queues one
// job when some port is to be sent on; the back end then gives one result
// per cycle, up to eight for one job, through a single output register, so
// sustained output rate is set by that register and by rsp_ready. Config
// writes take effect at once and there is no clearing pass after reset.
module spanning_tree_root_election
   import stre_pkg::*;
#(
   parameter int PORTS     = 8,
   parameter int COST_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   queue_status_type q_status;
   logic             push, pop;
   job_type          push_job, head;

   stre_front #(
      .PORTS     (PORTS),
      .COST_BITS (COST_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   stre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   stre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/stre_checker.sv =====
// Port-level checks for spanning_tree_root_election, bound to the top.
// Uses stre_pkg.
module stre_checker
   import stre_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   logic              in_run_ff;
   logic [PORT_W-1:0] prev_port_ff;
   logic [ID_W-1:0]   prev_root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         in_run_ff <= ~rsp_data.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         prev_port_ff <= rsp_data.out_port;
         prev_root_ff <= rsp_data.out_root_id;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_root_port: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.root_port <= NO_PORT)
      else $error("root port out of range");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_run_ff |->
         rsp_data.out_port > prev_port_ff && rsp_data.out_root_id == prev_root_ff)
      else $error("announcement run not ascending or root changed");

endmodule

bind spanning_tree_root_election stre_checker u_checker (.*);
